// File: design/spherical_to_cartesian_ray_defines.svh
// Assertion macros used by sphcart_checker, the spherical_to_cartesian_ray verification file.
// Requires nothing else; each macro expands to one concurrent assertion.
`ifndef SPHERICAL_TO_CARTESIAN_RAY_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_RAY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPHCART_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sphcart same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPHCART_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sphcart next-cycle check failed");

`endif

// File: design/sphcart_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the ray direction block.
// Used by sphcart_sincos and spherical_to_cartesian_ray; depends on nothing.
`default_nettype none

package sphcart_pkg;

    localparam int TURN_BITS    = 32;
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_ITERS = 30;
    localparam int SINCOS_LAT   = CORDIC_ITERS + 2;
    localparam int PROD_W       = 64;

    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam cordic_t CORDIC_GAIN_INV = 32'sd652032874;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Arctangent of 2^-idx in turns scaled by 2^32.
    function automatic cordic_t atan_turn(input int idx);
        cordic_t val;
        case (idx)
            0:       val = 32'sh20000000;
            1:       val = 32'sh12E4051E;
            2:       val = 32'sh09FB385B;
            3:       val = 32'sh051111D4;
            4:       val = 32'sh028B0D43;
            5:       val = 32'sh0145D7E1;
            6:       val = 32'sh00A2F61E;
            7:       val = 32'sh00517C55;
            8:       val = 32'sh0028BE53;
            9:       val = 32'sh00145F2F;
            10:      val = 32'sh000A2F98;
            11:      val = 32'sh000517CC;
            12:      val = 32'sh00028BE6;
            13:      val = 32'sh000145F3;
            14:      val = 32'sh0000A2FA;
            15:      val = 32'sh0000517D;
            16:      val = 32'sh000028BE;
            17:      val = 32'sh0000145F;
            18:      val = 32'sh00000A30;
            19:      val = 32'sh00000518;
            20:      val = 32'sh0000028C;
            21:      val = 32'sh00000146;
            22:      val = 32'sh000000A3;
            23:      val = 32'sh00000051;
            24:      val = 32'sh00000029;
            25:      val = 32'sh00000014;
            26:      val = 32'sh0000000A;
            27:      val = 32'sh00000005;
            28:      val = 32'sh00000003;
            29:      val = 32'sh00000001;
            default: val = 32'sh00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: design/spherical_to_cartesian_ray.sv
// Unit ray direction from elevation and azimuth binary angles.
// Two sphcart_sincos CORDIC pipelines feed a product and a rounding stage; uses sphcart_pkg.
//
// The block takes one transaction of two binary angles on the s_ channel and returns
// one transaction of three signed Q1.(OUT_BITS-1) components on the m_ channel:
// x = cos(az)cos(el), y = sin(az)cos(el), z = sin(el). A full circle is 2^ANGLE_BITS.
// Every input transaction yields exactly one output transaction, in order.
// From acceptance to m_tvalid a transaction passes one input stage, 30 CORDIC
// iteration stages, the quadrant fold, the multiply stage and the rounding stage,
// then the output register.
// Throughput is one transaction per cycle while s_tready is high; both angles
// run through their own CORDIC pipeline side by side, one iteration per stage.
// Reset clears all valid bits, so the output is empty and s_tready is high.
// When the receiver stalls, the output register holds its transaction and a skid
// register catches the next one; s_tready then drops and the whole pipeline holds
// until the receiver takes the waiting transaction.
`default_nettype none

module spherical_to_cartesian_ray #(
    parameter int ANGLE_BITS = 16,
    parameter int OUT_BITS   = 16,
    localparam int S_DATA_W  = ((2 * ANGLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((3 * OUT_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // elevation_angle, azimuth_angle, zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // dir_x, dir_y, dir_z, zero fill
);

    localparam int PIPE_LAT = sphcart_pkg::SINCOS_LAT + 2;
    localparam int RES_W    = 3 * OUT_BITS;
    localparam int XY_SHIFT = 61 - OUT_BITS;
    localparam int Z_SHIFT  = 31 - OUT_BITS;

    localparam sphcart_pkg::prod_t XY_HALF = sphcart_pkg::prod_t'(1) <<< (XY_SHIFT - 1);
    localparam sphcart_pkg::prod_t Z_HALF  = sphcart_pkg::prod_t'(1) <<< (Z_SHIFT - 1);
    localparam sphcart_pkg::prod_t OUT_MAX = (sphcart_pkg::prod_t'(1) <<< (OUT_BITS - 1)) - 1;
    localparam sphcart_pkg::prod_t OUT_MIN = -(sphcart_pkg::prod_t'(1) <<< (OUT_BITS - 1));

    function automatic logic signed [OUT_BITS-1:0] sat_out(input sphcart_pkg::prod_t r);
        logic signed [OUT_BITS-1:0] val;
        if (r > OUT_MAX)
        begin
            val = OUT_MAX[OUT_BITS-1:0];
        end
        else if (r < OUT_MIN)
        begin
            val = OUT_MIN[OUT_BITS-1:0];
        end
        else
        begin
            val = r[OUT_BITS-1:0];
        end
        return val;
    endfunction

    logic                 en;
    logic [PIPE_LAT-1:0]  vld_reg;
    sphcart_pkg::cordic_t cos_el;
    sphcart_pkg::cordic_t sin_el;
    sphcart_pkg::cordic_t cos_az;
    sphcart_pkg::cordic_t sin_az;

    sphcart_pkg::prod_t   prod_x_reg;
    sphcart_pkg::prod_t   prod_y_reg;
    sphcart_pkg::cordic_t sin_el_reg;

    sphcart_pkg::prod_t   round_x;
    sphcart_pkg::prod_t   round_y;
    sphcart_pkg::prod_t   round_z;
    logic [RES_W-1:0]     res_next;
    logic [RES_W-1:0]     res_reg;

    logic                 out_valid_reg;
    logic [RES_W-1:0]     out_data_reg;
    logic                 skid_valid_reg;
    logic [RES_W-1:0]     skid_data_reg;
    logic                 last_valid;

    assign en         = !skid_valid_reg;
    assign s_tready   = en;
    assign last_valid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    sphcart_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_elev (
        .clk     (clk),
        .en      (en),
        .angle   (s_tdata[ANGLE_BITS-1:0]),
        .cos_val (cos_el),
        .sin_val (sin_el)
    );

    sphcart_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_azim (
        .clk     (clk),
        .en      (en),
        .angle   (s_tdata[2*ANGLE_BITS-1 -: ANGLE_BITS]),
        .cos_val (cos_az),
        .sin_val (sin_az)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= sphcart_pkg::prod_t'(cos_az) * sphcart_pkg::prod_t'(cos_el);
            prod_y_reg <= sphcart_pkg::prod_t'(sin_az) * sphcart_pkg::prod_t'(cos_el);
            sin_el_reg <= sin_el;
        end
    end

    always_comb
    begin
        round_x  = (prod_x_reg + XY_HALF) >>> XY_SHIFT;
        round_y  = (prod_y_reg + XY_HALF) >>> XY_SHIFT;
        round_z  = (sphcart_pkg::prod_t'(sin_el_reg) + Z_HALF) >>> Z_SHIFT;
        res_next = {sat_out(round_z), sat_out(round_y), sat_out(round_x)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_valid;
            end
        end
        else if (last_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_reg;
        end
        else if (en)
        begin
            skid_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

endmodule

`default_nettype wire

// File: design/sphcart_sincos.sv
// Pipelined rotation-mode CORDIC giving Q2.30 cosine and sine of one binary angle.
// One iteration per register stage, then a registered quadrant fold; uses sphcart_pkg.
`default_nettype none

module sphcart_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [ANGLE_BITS-1:0] angle,
    output sphcart_pkg::cordic_t cos_val,
    output sphcart_pkg::cordic_t sin_val
);

    localparam int ITERS = sphcart_pkg::CORDIC_ITERS;

    sphcart_pkg::cordic_t x_reg [0:ITERS];
    sphcart_pkg::cordic_t y_reg [0:ITERS];
    sphcart_pkg::cordic_t z_reg [0:ITERS-1];
    logic [1:0]           quad_reg [0:ITERS];
    sphcart_pkg::cordic_t cos_reg;
    sphcart_pkg::cordic_t sin_reg;

    logic [sphcart_pkg::TURN_BITS-1:0] turns;

    assign turns = sphcart_pkg::TURN_BITS'(angle) << (sphcart_pkg::TURN_BITS - ANGLE_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= sphcart_pkg::CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= {2'b00, turns[sphcart_pkg::TURN_BITS-3:0]};
            quad_reg[0] <= turns[sphcart_pkg::TURN_BITS-1 -: 2];
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        sphcart_pkg::cordic_t dx;
        sphcart_pkg::cordic_t dy;
        sphcart_pkg::cordic_t x_next;
        sphcart_pkg::cordic_t y_next;
        logic                 rot_pos;

        assign dx      = x_reg[i] >>> i;
        assign dy      = y_reg[i] >>> i;
        assign rot_pos = !z_reg[i][sphcart_pkg::CORDIC_W-1];

        always_comb
        begin
            if (rot_pos)
            begin
                x_next = x_reg[i] - dy;
                y_next = y_reg[i] + dx;
            end
            else
            begin
                x_next = x_reg[i] + dy;
                y_next = y_reg[i] - dx;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                quad_reg[i+1] <= quad_reg[i];
            end
        end

        if (i < ITERS - 1)
        begin : g_angle
            sphcart_pkg::cordic_t z_next;

            assign z_next = rot_pos ? z_reg[i] - sphcart_pkg::atan_turn(i)
                                    : z_reg[i] + sphcart_pkg::atan_turn(i);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i+1] <= z_next;
                end
            end
        end
    end

    sphcart_pkg::cordic_t cos_next;
    sphcart_pkg::cordic_t sin_next;

    always_comb
    begin
        case (quad_reg[ITERS])
            sphcart_pkg::QUAD_0:
            begin
                cos_next = x_reg[ITERS];
                sin_next = y_reg[ITERS];
            end
            sphcart_pkg::QUAD_1:
            begin
                cos_next = -y_reg[ITERS];
                sin_next = x_reg[ITERS];
            end
            sphcart_pkg::QUAD_2:
            begin
                cos_next = -x_reg[ITERS];
                sin_next = -y_reg[ITERS];
            end
            default:
            begin
                cos_next = y_reg[ITERS];
                sin_next = -x_reg[ITERS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// File: design/sphcart_checker.sv
// Port-level assertions for spherical_to_cartesian_ray and the bind that attaches them.
// Depends on spherical_to_cartesian_ray_defines.svh for the assertion macros.
`default_nettype none

`include "spherical_to_cartesian_ray_defines.svh"

module sphcart_checker #(
    parameter int M_DATA_W = 48
) (
    input wire                clk,
    input wire                rst_n,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);

    `SPHCART_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `SPHCART_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `SPHCART_ASSERT_NOW(a_stall_needs_output, clk, rst_n, !s_tready, m_tvalid)
    `SPHCART_ASSERT_NEXT(a_stall_clears, clk, rst_n, !s_tready && m_tready, s_tready)

endmodule

bind spherical_to_cartesian_ray sphcart_checker #(
    .M_DATA_W (M_DATA_W)
) u_sphcart_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
